// ===== rtl/cfba_pkg.sv =====
// ============================================================================
// cfba_pkg: chunked fixed block allocator package
// Shared types, status codes, register indexes and reset values.
// ============================================================================
package cfba_pkg;

    localparam int BLK_W      = 8;
    localparam int MAX_BLOCKS = 256;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [7:0] DEF_BLOCK_SIZE = 8'd1;
    localparam logic [7:0] DEF_BLOCKS     = 8'd255;
    localparam logic [6:0] DEF_CHUNKS     = 7'd50;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCKS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHUNKS     = 2'd2;

    typedef enum logic [1:0] {
        ST_ALLOC   = 2'd0,
        ST_OOM     = 2'd1,
        ST_FREED   = 2'd2,
        ST_IGNORED = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FREE,
        S_IGNORE,
        S_CUR,
        S_SCAN,
        S_LINK
    } state_t;

endpackage

// ===== rtl/cfba_ram.sv =====
// ============================================================================
// cfba_ram: simple dual-port synchronous RAM
// One write port and one read port, read data registered.
// ============================================================================
module cfba_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int WIDTH  = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // hold read data until the next read
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/chunked_fixed_block_allocator.sv =====
// ============================================================================
// chunked_fixed_block_allocator: fixed-size block allocator over chunks
// Free lists threaded through a link RAM, one head/count entry per chunk.
// ============================================================================
// Usage:
//   Requests enter on in_valid/in_ready with req_type (0 allocate, 1 free)
//   and, for a free, free_chunk and free_block. Every request gives exactly
//   one result on out_valid/out_ready: status, got_chunk, got_block and
//   byte_offset (block index times block size).
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data); any
//   write to a known register restarts the allocator with all chunks full.
//   Requests: one request at a time, accepted in the idle state. A free
//   passes through S_FREE, an ignored free through S_IGNORE, an allocate
//   from the current chunk through S_CUR and S_LINK. When no current chunk
//   is usable the allocator walks the chunk table from chunk zero, one entry
//   per cycle, until it finds a chunk with a free block or reaches the last.
//   Reset and every restart run a clearing pass over all NUM_CHUNKS*256 link
//   entries (16384 by default) that rewrites the link RAM and the chunk table;
//   in_ready stays low meanwhile.
//   When the receiver stalls, the result waits in the output register and
//   the allocator holds its last step, with no RAM write, until it drains.
// ============================================================================
module chunked_fixed_block_allocator
    import cfba_pkg::*;
#(
    parameter  int NUM_CHUNKS = 64,
    localparam int CHUNK_W    = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  req_type,
    input  logic [CHUNK_W-1:0]    free_chunk,
    input  logic [BLK_W-1:0]      free_block,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            status,
    output logic [CHUNK_W-1:0]    got_chunk,
    output logic [BLK_W-1:0]      got_block,
    output logic [15:0]           byte_offset,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int LINK_AW    = CHUNK_W + BLK_W;
    localparam int LINK_DEPTH = NUM_CHUNKS * MAX_BLOCKS;
    localparam logic [LINK_AW-1:0] CLR_LAST = LINK_AW'(LINK_DEPTH - 1);
    localparam logic [7:0] NC_MAX = 8'(NUM_CHUNKS);

    // configuration registers
    logic [7:0] block_size_reg;
    logic [7:0] blocks_reg;
    logic [6:0] chunks_reg;
    logic       cfg_hit;

    // effective values: zero selects the default, chunk count saturates
    logic [7:0] bs_eff;
    logic [7:0] nb_eff;
    logic [7:0] nc_raw;
    logic [7:0] nc_eff;

    // sequencer state
    state_t               state_reg, state_next;
    logic [LINK_AW-1:0]   clr_reg, clr_next;
    logic [CHUNK_W-1:0]   scan_reg, scan_next;
    logic [CHUNK_W-1:0]   cur_reg, cur_next;
    logic                 cur_valid_reg, cur_valid_next;
    logic [CHUNK_W-1:0]   fc_reg, fc_next;
    logic [BLK_W-1:0]     fb_reg, fb_next;

    // output register
    logic                 out_valid_reg;
    logic [1:0]           status_reg;
    logic [CHUNK_W-1:0]   got_chunk_reg;
    logic [BLK_W-1:0]     got_block_reg;
    logic [15:0]          offset_reg;
    logic                 out_free;
    logic                 out_load;
    status_t              ld_status;
    logic [CHUNK_W-1:0]   ld_chunk;
    logic [BLK_W-1:0]     ld_block;
    logic [15:0]          ld_offset;

    // RAM ports
    logic                 ch_we, ch_re;
    logic [CHUNK_W-1:0]   ch_waddr, ch_raddr;
    logic [15:0]          ch_wdata, ch_rdata;
    logic                 lk_we, lk_re;
    logic [LINK_AW-1:0]   lk_waddr, lk_raddr;
    logic [BLK_W-1:0]     lk_wdata, lk_rdata;

    logic [BLK_W-1:0]     head;
    logic [7:0]           count;
    logic [15:0]          product;
    logic                 free_ok;
    logic                 scan_last;

    assign cfg_hit = cfg_we && (cfg_index inside {REG_BLOCK_SIZE, REG_BLOCKS, REG_CHUNKS});

    assign bs_eff = (block_size_reg == 8'd0) ? DEF_BLOCK_SIZE : block_size_reg;
    assign nb_eff = (blocks_reg == 8'd0) ? DEF_BLOCKS : blocks_reg;
    assign nc_raw = {1'b0, (chunks_reg == 7'd0) ? DEF_CHUNKS : chunks_reg};
    assign nc_eff = (nc_raw > NC_MAX) ? NC_MAX : nc_raw;

    // chunk table entry: head in the upper byte, free count in the lower
    assign head  = ch_rdata[15:8];
    assign count = ch_rdata[7:0];

    assign product   = {8'd0, head} * {8'd0, bs_eff};
    assign free_ok   = (8'(free_chunk) < nc_eff) && (free_block < nb_eff);
    assign scan_last = ((8'(scan_reg) + 8'd1) == nc_eff);
    assign out_free  = !out_valid_reg || out_ready;

    cfba_ram #(
        .DEPTH  (NUM_CHUNKS),
        .ADDR_W (CHUNK_W),
        .WIDTH  (16)
    ) u_chunk_ram (
        .clk   (clk),
        .we    (ch_we),
        .waddr (ch_waddr),
        .wdata (ch_wdata),
        .re    (ch_re),
        .raddr (ch_raddr),
        .rdata (ch_rdata)
    );

    cfba_ram #(
        .DEPTH  (LINK_DEPTH),
        .ADDR_W (LINK_AW),
        .WIDTH  (BLK_W)
    ) u_link_ram (
        .clk   (clk),
        .we    (lk_we),
        .waddr (lk_waddr),
        .wdata (lk_wdata),
        .re    (lk_re),
        .raddr (lk_raddr),
        .rdata (lk_rdata)
    );

    // configuration registers: reset to the power-on defaults
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg <= DEF_BLOCK_SIZE;
            blocks_reg     <= DEF_BLOCKS;
            chunks_reg     <= DEF_CHUNKS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BLOCK_SIZE: block_size_reg <= cfg_data;
                REG_BLOCKS:     blocks_reg     <= cfg_data;
                REG_CHUNKS:     chunks_reg     <= cfg_data[6:0];
                default:        ;
            endcase
        end
    end

    // sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            scan_reg      <= '0;
            cur_reg       <= '0;
            cur_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            scan_reg      <= scan_next;
            cur_reg       <= cur_next;
            cur_valid_reg <= cur_valid_next;
        end
    end

    // captured free request (payload, no reset)
    always_ff @(posedge clk)
    begin
        fc_reg <= fc_next;
        fb_reg <= fb_next;
    end

    // next state, RAM accesses and result load
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        scan_next      = scan_reg;
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        fc_next        = fc_reg;
        fb_next        = fb_reg;

        ch_we    = 1'b0;
        ch_waddr = cur_reg;
        ch_wdata = {lk_rdata, 8'(count - 8'd1)};
        ch_re    = 1'b0;
        ch_raddr = '0;
        lk_we    = 1'b0;
        lk_waddr = {fc_reg, fb_reg};
        lk_wdata = head;
        lk_re    = 1'b0;
        lk_raddr = {cur_reg, head};

        out_load  = 1'b0;
        ld_status = ST_ALLOC;
        ld_chunk  = '0;
        ld_block  = '0;
        ld_offset = '0;

        in_ready = (state_reg == S_IDLE);

        case (state_reg)
            S_CLEAR:
            begin
                // rebuild each list in index order, every chunk full
                lk_we    = 1'b1;
                lk_waddr = clr_reg;
                lk_wdata = clr_reg[BLK_W-1:0] + 8'd1;
                if (clr_reg[BLK_W-1:0] == '0)
                begin
                    ch_we    = 1'b1;
                    ch_waddr = clr_reg[LINK_AW-1:BLK_W];
                    ch_wdata = {8'd0, nb_eff};
                end
                if (clr_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (req_type)
                    begin
                        fc_next = free_chunk;
                        fb_next = free_block;
                        if (free_ok)
                        begin
                            ch_re      = 1'b1;
                            ch_raddr   = free_chunk;
                            state_next = S_FREE;
                        end
                        else
                        begin
                            state_next = S_IGNORE;
                        end
                    end
                    else if (cur_valid_reg)
                    begin
                        ch_re      = 1'b1;
                        ch_raddr   = cur_reg;
                        state_next = S_CUR;
                    end
                    else
                    begin
                        ch_re      = 1'b1;
                        scan_next  = '0;
                        state_next = S_SCAN;
                    end
                end
            end

            S_FREE:
            begin
                // push the block onto its chunk's list
                if (out_free)
                begin
                    lk_we      = 1'b1;
                    ch_we      = 1'b1;
                    ch_waddr   = fc_reg;
                    ch_wdata   = {fb_reg, 8'(count + 8'd1)};
                    out_load   = 1'b1;
                    ld_status  = ST_FREED;
                    state_next = S_IDLE;
                end
            end

            S_IGNORE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    ld_status  = ST_IGNORED;
                    state_next = S_IDLE;
                end
            end

            S_CUR:
            begin
                if (count != 8'd0)
                begin
                    lk_re      = 1'b1;
                    state_next = S_LINK;
                end
                else
                begin
                    // current chunk exhausted: walk the table from chunk zero
                    ch_re      = 1'b1;
                    scan_next  = '0;
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (count != 8'd0)
                begin
                    cur_next       = scan_reg;
                    cur_valid_next = 1'b1;
                    lk_re          = 1'b1;
                    lk_raddr       = {scan_reg, head};
                    state_next     = S_LINK;
                end
                else if (scan_last)
                begin
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        ld_status  = ST_OOM;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    ch_re     = 1'b1;
                    ch_raddr  = scan_reg + 1'b1;
                    scan_next = scan_reg + 1'b1;
                end
            end

            S_LINK:
            begin
                // pop the head: the link read gives the new head
                if (out_free)
                begin
                    ch_we      = 1'b1;
                    out_load   = 1'b1;
                    ld_status  = ST_ALLOC;
                    ld_chunk   = cur_reg;
                    ld_block   = head;
                    ld_offset  = product;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_CLEAR;
                clr_next   = '0;
            end
        endcase

        // a register write restarts the allocator
        if (cfg_hit)
        begin
            state_next     = S_CLEAR;
            clr_next       = '0;
            cur_valid_next = 1'b0;
        end
    end

    // output register: load a result, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg    <= ld_status;
            got_chunk_reg <= ld_chunk;
            got_block_reg <= ld_block;
            offset_reg    <= ld_offset;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign got_chunk   = got_chunk_reg;
    assign got_block   = got_block_reg;
    assign byte_offset = offset_reg;

endmodule

// ===== rtl/cfba_check.sv =====
// ============================================================================
// cfba_check: port-level checker for the block allocator
// Watches the top-level ports and flags results that break the contract.
// ============================================================================
module cfba_check
    import cfba_pkg::*;
#(
    parameter int CHUNK_W = 6
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  req_type,
    input logic [CHUNK_W-1:0]    free_chunk,
    input logic [BLK_W-1:0]      free_block,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [1:0]            status,
    input logic [CHUNK_W-1:0]    got_chunk,
    input logic [BLK_W-1:0]      got_block,
    input logic [15:0]           byte_offset,
    input logic                  cfg_we,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(got_block) && $stable(byte_offset))
    else $error("stalled result changed");

    // only an allocation carries a handle
    a_no_handle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_ALLOC) |->
            (got_chunk == '0) && (got_block == '0) && (byte_offset == '0))
    else $error("non-allocation result carries a handle");

    // one request at a time: no accept right after an accept
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("request accepted while one is in progress");

    // block index zero always maps to byte offset zero
    a_zero_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_ALLOC) && (got_block == '0) |-> (byte_offset == '0))
    else $error("offset of block zero is not zero");

endmodule

bind chunked_fixed_block_allocator cfba_check #(.CHUNK_W(CHUNK_W)) u_cfba_check (.*);

// ===== test/tb_chunked_fixed_block_allocator.sv =====
// ============================================================================
// tb_chunked_fixed_block_allocator: allocator self-checking testbench
// Drives allocate and free requests, predicts every answer with a software
// copy of the chunk free lists, and checks each result field by field.
// ============================================================================
module tb_chunked_fixed_block_allocator;
    import cfba_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PERIOD          = 20;
    localparam int CHUNK_COUNT     = 64;
    localparam int ITEMS_PER_PHASE = 204;
    localparam int HOLD_CYCLES     = 300;
    // A restart clears 64*256 entries; allow several clearing passes of silence.
    localparam int WATCHDOG_LIMIT  = 4 * CHUNK_COUNT * MAX_BLOCKS;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // One answer of the allocator, as it appears on the result channel.
    typedef struct packed {
        status_t     code;
        logic [5:0]  chunk;
        logic [7:0]  blk;
        logic [15:0] offset;
    } alloc_result_t;

    // One line of the directed table: either a register write or a request,
    // the latter with an optional hand-written answer.
    typedef struct packed {
        bit            is_reg;
        logic [1:0]    reg_idx;
        logic [7:0]    reg_val;
        logic          rt;
        logic [5:0]    fc;
        logic [7:0]    fb;
        bit            known;
        alloc_result_t typed;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        req_type;
    logic [5:0]  free_chunk;
    logic [7:0]  free_block;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [5:0]  got_chunk;
    logic [7:0]  got_block;
    logic [15:0] byte_offset;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;

    // Software image of the allocator: links, list heads, free counts.
    logic [7:0] chain_next [CHUNK_COUNT][MAX_BLOCKS];
    logic [7:0] list_head [CHUNK_COUNT];
    logic [7:0] spare_count [CHUNK_COUNT];
    logic [5:0] active_chunk;
    logic       active_ok;
    logic [7:0] size_reg;
    logic [7:0] blocks_reg;
    logic [6:0] chunks_reg;

    alloc_result_t pending_answers [$];
    logic [13:0]   held_handles [$];   // {chunk, block} handed out and not yet freed
    plan_row_t     plan [$];

    int mismatches   = 0;
    int idle_cycles  = 0;
    bit no_idle      = 1'b0;
    bit hold_pending = 1'b0;

    chunked_fixed_block_allocator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .free_chunk  (free_chunk),
        .free_block  (free_block),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .got_chunk   (got_chunk),
        .got_block   (got_block),
        .byte_offset (byte_offset),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #(PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // Effective register values: zero selects the default, the chunk count
    // saturates at the number of chunks built into the block.
    // ------------------------------------------------------------------------
    function automatic int unsigned eff_blocks();
        if (blocks_reg == 8'd0)
            return DEF_BLOCKS;
        return blocks_reg;
    endfunction

    function automatic int unsigned eff_chunks();
        int unsigned c;
        c = (chunks_reg == 7'd0) ? DEF_CHUNKS : chunks_reg;
        return (c > CHUNK_COUNT) ? CHUNK_COUNT : c;
    endfunction

    function automatic logic [15:0] eff_size();
        return {8'd0, (size_reg == 8'd0) ? DEF_BLOCK_SIZE : size_reg};
    endfunction

    // Restart: every chunk full, every list in index order, no current chunk.
    function automatic void refill_chunks();
        for (int c = 0; c < CHUNK_COUNT; c++)
        begin
            for (int b = 0; b < MAX_BLOCKS; b++)
                chain_next[c][b] = 8'(b + 1);
            list_head[c]   = 8'd0;
            spare_count[c] = 8'(eff_blocks());
        end
        active_chunk = 6'd0;
        active_ok    = 1'b0;
    endfunction

    // Advance the image by one request and return the answer it must give.
    function automatic alloc_result_t allocator_answer(input logic rt,
                                                       input logic [5:0] fc,
                                                       input logic [7:0] fb);
        alloc_result_t ans;
        int unsigned   nc;
        int unsigned   nb;
        logic [7:0]    blk;
        bit            found;
        ans = '0;
        nc  = eff_chunks();
        nb  = eff_blocks();
        if (rt == REQ_ALLOC)
        begin
            // Stay on the current chunk while it has blocks, else take the
            // lowest-numbered chunk that still has one.
            if (!active_ok || active_chunk >= nc || spare_count[active_chunk] == 8'd0)
            begin
                found = 1'b0;
                for (int c = 0; c < nc; c++)
                begin
                    if (!found && spare_count[c] != 8'd0)
                    begin
                        found        = 1'b1;
                        active_chunk = 6'(c);
                    end
                end
                if (!found)
                begin
                    ans.code = ST_OOM;    // current chunk is kept
                    return ans;
                end
                active_ok = 1'b1;
            end
            // A corrupted list (double free) may hand back a stale head as is.
            blk                       = list_head[active_chunk];
            list_head[active_chunk]   = chain_next[active_chunk][blk];
            spare_count[active_chunk] = spare_count[active_chunk] - 8'd1;
            ans.code   = ST_ALLOC;
            ans.chunk  = active_chunk;
            ans.blk    = blk;
            ans.offset = {8'd0, blk} * eff_size();
        end
        else if (fc >= nc || fb >= nb)
        begin
            ans.code = ST_IGNORED;
        end
        else
        begin
            // Push onto the chunk's list; double frees are pushed again and
            // the 8-bit count wraps.
            chain_next[fc][fb] = list_head[fc];
            list_head[fc]      = fb;
            spare_count[fc]    = spare_count[fc] + 8'd1;
            ans.code           = ST_FREED;
        end
        return ans;
    endfunction

    function automatic plan_row_t req_row(input logic rt, input logic [5:0] fc,
                                          input logic [7:0] fb, input bit known,
                                          input status_t code, input logic [5:0] ch,
                                          input logic [7:0] bk, input logic [15:0] off);
        plan_row_t r;
        r              = '0;
        r.rt           = rt;
        r.fc           = fc;
        r.fb           = fb;
        r.known        = known;
        r.typed.code   = code;
        r.typed.chunk  = ch;
        r.typed.blk    = bk;
        r.typed.offset = off;
        return r;
    endfunction

    function automatic plan_row_t reg_row(input logic [1:0] idx, input logic [7:0] value);
        plan_row_t r;
        r         = '0;
        r.is_reg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = value;
        return r;
    endfunction

    // Append one line to the directed table.
    function automatic void stage_row(input plan_row_t r);
        plan.insert(plan.size(), r);
    endfunction

    // ------------------------------------------------------------------------
    // Request side: wait a random gap, offer the request, hold it until it is
    // accepted, then record the expected answer. Valid stays high on return;
    // the next call either replaces the payload or drops valid.
    // ------------------------------------------------------------------------
    task automatic send_request(input logic rt, input logic [5:0] fc, input logic [7:0] fb,
                                input bit known, input alloc_result_t typed);
        int            gap;
        alloc_result_t ans;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= rt;
        free_chunk <= fc;
        free_block <= fb;
        do
            @(posedge clk);
        while (!in_ready);
        ans = allocator_answer(rt, fc, fb);
        if (ans.code == ST_ALLOC)
            held_handles.insert(held_handles.size(), {ans.chunk, ans.blk});
        pending_answers.insert(pending_answers.size(), known ? typed : ans);
    endtask

    // Drop valid and hold until every answer is back and the block is idle.
    task automatic wait_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_answers.size() != 0 || !in_ready)
            @(negedge clk);
    endtask

    // Any register write restarts the allocator, so only write when idle.
    task automatic write_register(input logic [1:0] idx, input logic [7:0] value);
        wait_until_drained();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_BLOCK_SIZE: size_reg   = value;
            REG_BLOCKS:     blocks_reg = value;
            REG_CHUNKS:     chunks_reg = value[6:0];
            default:        ;
        endcase
        refill_chunks();
        held_handles.delete();
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result side: draw a stall per result (or the long hold-off when asked),
    // then take the result and compare it with the oldest expectation.
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int            stall;
        alloc_result_t want;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 19);
            if (hold_pending)
            begin
                stall        = HOLD_CYCLES;
                hold_pending = 1'b0;
            end
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            if (pending_answers.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got status %0d chunk %0d",
                         $time, status, got_chunk);
                $display("%0t:   block %0d offset %0d", $time, got_block, byte_offset);
                mismatches++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (status !== want.code)
                begin
                    $display("%0t: status expected %0d, got %0d", $time, want.code, status);
                    mismatches++;
                end
                if (got_chunk !== want.chunk)
                begin
                    $display("%0t: got_chunk expected %0d, got %0d", $time, want.chunk, got_chunk);
                    mismatches++;
                end
                if (got_block !== want.blk)
                begin
                    $display("%0t: got_block expected %0d, got %0d", $time, want.blk, got_block);
                    mismatches++;
                end
                if (byte_offset !== want.offset)
                begin
                    $display("%0t: byte_offset expected %0d, got %0d",
                             $time, want.offset, byte_offset);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: count cycles in which nothing moves on either channel or the
    // register port. The clearing pass after each restart fits well inside.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus: directed table first, then random phases over several
    // register settings.
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int         pick;
        int         alloc_bias;
        logic [7:0] bs;
        logic [7:0] bl;
        logic [6:0] ch;
        logic [5:0] fc;
        logic [7:0] fb;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        req_type   = REQ_ALLOC;
        free_chunk = 6'd0;
        free_block = 8'd0;
        cfg_we     = 1'b0;
        cfg_index  = REG_BLOCK_SIZE;
        cfg_data   = 8'd0;
        size_reg   = DEF_BLOCK_SIZE;
        blocks_reg = DEF_BLOCKS;
        chunks_reg = DEF_CHUNKS;
        refill_chunks();

        // Default settings after reset: 1 byte blocks, 255 blocks, 50 chunks.
        stage_row(req_row(REQ_ALLOC, 6'd0, 8'd0, 1, ST_ALLOC, 6'd0, 8'd0, 16'd0));
        // allocate with the unused free fields at their extremes
        stage_row(req_row(REQ_ALLOC, 6'd63, 8'd255, 1, ST_ALLOC, 6'd0, 8'd1, 16'd1));
        stage_row(req_row(REQ_FREE, 6'd0, 8'd0, 1, ST_FREED, 6'd0, 8'd0, 16'd0));
        // last freed block comes back first
        stage_row(req_row(REQ_ALLOC, 6'd0, 8'd0, 1, ST_ALLOC, 6'd0, 8'd0, 16'd0));
        // double free into a full chunk: count wraps, chunk then looks empty
        stage_row(req_row(REQ_FREE, 6'd49, 8'd254, 1, ST_FREED, 6'd0, 8'd0, 16'd0));
        // out-of-range frees: chunk past the count, block past the count
        stage_row(req_row(REQ_FREE, 6'd50, 8'd0, 1, ST_IGNORED, 6'd0, 8'd0, 16'd0));
        stage_row(req_row(REQ_FREE, 6'd63, 8'd255, 1, ST_IGNORED, 6'd0, 8'd0, 16'd0));
        stage_row(req_row(REQ_FREE, 6'd0, 8'd255, 1, ST_IGNORED, 6'd0, 8'd0, 16'd0));
        stage_row(req_row(REQ_FREE, 6'd0, 8'd1, 1, ST_FREED, 6'd0, 8'd0, 16'd0));
        stage_row(req_row(REQ_ALLOC, 6'd0, 8'd0, 1, ST_ALLOC, 6'd0, 8'd1, 16'd1));

        // Two chunks of one block each: scan to the next chunk, then run out.
        stage_row(reg_row(REG_BLOCK_SIZE, 8'd255));
        stage_row(reg_row(REG_BLOCKS, 8'd1));
        stage_row(reg_row(REG_CHUNKS, 8'd2));
        stage_row(req_row(REQ_ALLOC, 6'd0, 8'd0, 1, ST_ALLOC, 6'd0, 8'd0, 16'd0));
        stage_row(req_row(REQ_ALLOC, 6'd0, 8'd0, 1, ST_ALLOC, 6'd1, 8'd0, 16'd0));
        stage_row(req_row(REQ_ALLOC, 6'd0, 8'd0, 1, ST_OOM, 6'd0, 8'd0, 16'd0));
        stage_row(req_row(REQ_FREE, 6'd2, 8'd0, 1, ST_IGNORED, 6'd0, 8'd0, 16'd0));
        stage_row(req_row(REQ_FREE, 6'd0, 8'd1, 1, ST_IGNORED, 6'd0, 8'd0, 16'd0));
        stage_row(req_row(REQ_FREE, 6'd0, 8'd0, 1, ST_FREED, 6'd0, 8'd0, 16'd0));
        // current chunk is empty, scan back to chunk 0
        stage_row(req_row(REQ_ALLOC, 6'd0, 8'd0, 0, ST_ALLOC, 6'd0, 8'd0, 16'd0));

        // Zero block count acts as 255, chunk count 127 saturates at 64.
        stage_row(reg_row(REG_BLOCKS, 8'd0));
        stage_row(reg_row(REG_CHUNKS, 8'd127));
        stage_row(req_row(REQ_ALLOC, 6'd0, 8'd0, 1, ST_ALLOC, 6'd0, 8'd0, 16'd0));
        stage_row(req_row(REQ_FREE, 6'd0, 8'd254, 1, ST_FREED, 6'd0, 8'd0, 16'd0));
        // largest offset: block 254 times 255 bytes
        stage_row(req_row(REQ_ALLOC, 6'd0, 8'd0, 1, ST_ALLOC, 6'd0, 8'd254, 16'd64770));
        stage_row(req_row(REQ_FREE, 6'd63, 8'd254, 1, ST_FREED, 6'd0, 8'd0, 16'd0));
        stage_row(req_row(REQ_FREE, 6'd0, 8'd255, 1, ST_IGNORED, 6'd0, 8'd0, 16'd0));
        stage_row(req_row(REQ_ALLOC, 6'd0, 8'd0, 0, ST_ALLOC, 6'd0, 8'd0, 16'd0));

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].is_reg)
                write_register(plan[i].reg_idx, plan[i].reg_val);
            else
                send_request(plan[i].rt, plan[i].fc, plan[i].fb, plan[i].known, plan[i].typed);
        end

        // Random phases. Small settings run out of memory often, which drives
        // the chunk scan and the out-of-memory path; large ones go deep into
        // the lists. Zero and oversized register values are mixed in.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:       {bs, bl, ch} = {8'd0,   8'd3,   7'd2};
                1:       {bs, bl, ch} = {8'd255, 8'd1,   7'd1};
                2:       {bs, bl, ch} = {8'd37,  8'd5,   7'd3};
                3:       {bs, bl, ch} = {8'd1,   8'd255, 7'd64};
                4:       {bs, bl, ch} = {8'd200, 8'd2,   7'd0};
                5:       {bs, bl, ch} = {8'd128, 8'd0,   7'd4};
                6:       {bs, bl, ch} = {8'd17,  8'd4,   7'd127};
                default: {bs, bl, ch} = {8'd255, 8'd7,   7'd64};
            endcase
            write_register(REG_BLOCK_SIZE, bs);
            write_register(REG_BLOCKS, bl);
            write_register(REG_CHUNKS, {1'b0, ch});

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // a stretch of back-to-back traffic on both sides
                no_idle = (n >= ITEMS_PER_PHASE / 4 && n < ITEMS_PER_PHASE / 4 + 40);
                // long result stall while requests keep coming
                if (ph == 1 && n == ITEMS_PER_PHASE / 2)
                    hold_pending = 1'b1;
                // pause requests until every answer is back
                if (ph == 2 && n == ITEMS_PER_PHASE / 2)
                    wait_until_drained();

                // alternate allocate-heavy and free-heavy bursts
                alloc_bias = ((n / 30) % 2 == 0) ? 75 : 25;
                if ($urandom_range(0, 99) < alloc_bias)
                begin
                    send_request(REQ_ALLOC, 6'($urandom_range(0, 63)),
                                 8'($urandom_range(0, 255)), 0, '0);
                end
                else if (held_handles.size() != 0 && $urandom_range(0, 9) != 0)
                begin
                    // well-formed free of a block that is out
                    pick     = $urandom_range(0, held_handles.size() - 1);
                    {fc, fb} = held_handles[pick];
                    held_handles.delete(pick);
                    send_request(REQ_FREE, fc, fb, 0, '0);
                end
                else
                begin
                    // noise: out-of-range or double frees
                    send_request(REQ_FREE, 6'($urandom_range(0, 63)),
                                 8'($urandom_range(0, 255)), 0, '0);
                end
            end
        end
        no_idle = 1'b0;

        wait_until_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/cfba_pkg.sv
rtl/cfba_ram.sv
rtl/chunked_fixed_block_allocator.sv
rtl/cfba_check.sv
test/tb_chunked_fixed_block_allocator.sv
